@@ design/svae_pkg.sv @@
// Shared constants and payload layouts for the voice allocator with envelopes.
// Depends on nothing; imported by synth_voice_allocator_envelope.
package svae_pkg;

  localparam int LVL_W       = 25;
  localparam int SLOT_IN_W   = 11;
  localparam int VOICE_OUT_W = 5;
  localparam int PHASE_W     = 2;
  localparam int OP_W        = 2;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 32;

  localparam int NUM_VOICES = 32;
  localparam int NUM_SLOTS  = 2048;

  // Q1.24 levels held in 25 bits
  localparam logic [LVL_W-1:0] LVL_MAX  = 25'h1FFFFFF;
  localparam logic [LVL_W-1:0] ONE_Q    = 25'h1000000;
  localparam logic [LVL_W-1:0] ATK_RST  = 25'd167772;
  localparam logic [LVL_W-1:0] SUS_RST  = 25'd8388608;
  localparam logic [LVL_W-1:0] HOLD_RST = 25'd16773861;
  localparam logic [LVL_W-1:0] REL_RST  = 25'd16767150;

  localparam logic [PHASE_W-1:0] PH_REL  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HOLD = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ATK  = 2'd2;

  localparam logic [OP_W-1:0] OP_ROW  = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE = 2'd1;
  localparam logic [OP_W-1:0] OP_HOLD = 2'd2;
  localparam logic [OP_W-1:0] OP_STEP = 2'd3;

  // Request payload, slot in the lowest bits
  typedef struct packed {
    logic                 pad;
    logic [LVL_W-1:0]     release_factor;
    logic [LVL_W-1:0]     hold_factor;
    logic [LVL_W-1:0]     sustain_level;
    logic [LVL_W-1:0]     attack_step;
    logic [SLOT_IN_W-1:0] slot;
  } in_data_t;

  // Result payload, voice in the lowest bits
  typedef struct packed {
    logic [PHASE_W-1:0]     phase;
    logic [LVL_W-1:0]       level;
    logic [VOICE_OUT_W-1:0] voice;
  } out_data_t;

endpackage

@@ design/synth_voice_allocator_envelope.sv @@
// Polyphonic voice pool with voice stealing and per-voice envelopes.
// Depends on svae_pkg for constants, opcodes and the stream payload layouts.
// After reset the block clears all SLOTS entries of the slot map (2048 by default) and takes
// no request meanwhile. Each request is handled on its own: sample_step, row_start and note_on
// walk the voice memory, one entry read per cycle while the output is not stalled, through a
// three-stage multiply pipeline; hold reads the slot map and, if the slot is mapped, one voice
// entry. A sample_step gives one result per voice in index order with tlast on the final one;
// every other request gives a single result. A result may wait in the output register while the
// next request is taken; a stalled output holds the voice walk.
module synth_voice_allocator_envelope
  import svae_pkg::*;
#(
  parameter int VOICES = NUM_VOICES,
  parameter int SLOTS  = NUM_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot[10:0], attack_step[35:11], sustain_level[60:36], hold_factor[85:61],
  // release_factor[110:86], zero[111]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // voice[4:0], level[29:5], phase[31:30]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // found[0]
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int VW   = $clog2(VOICES);
  localparam int SW   = $clog2(SLOTS);
  localparam int ModK = SLOT_IN_W + SW;
  localparam int ModM = ((1 << ModK) + SLOTS - 1) / SLOTS;
  localparam int MMW  = SLOT_IN_W + 2;
  localparam int PW   = SLOT_IN_W + MMW;

  localparam logic [VW-1:0] LastVoice = VW'(VOICES - 1);
  localparam logic [SW-1:0] LastSlot  = SW'(SLOTS - 1);

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LVL_W-1:0]   level;
    logic [LVL_W-1:0]   attack;
    logic [LVL_W-1:0]   sustain;
    logic [LVL_W-1:0]   hold_f;
    logic [LVL_W-1:0]   rel_f;
    logic [SW-1:0]      key;
  } ventry_t;

  typedef struct packed {
    logic          vld;
    logic [VW-1:0] owner;
  } sentry_t;

  localparam ventry_t RstEntry = '{phase: PH_ATK, level: '0, attack: ATK_RST,
                                   sustain: SUS_RST, hold_f: HOLD_RST, rel_f: REL_RST,
                                   key: '0};

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MOD1, ST_MOD2, ST_SWEEP, ST_DRAIN,
    ST_NOTE_RD, ST_NOTE_CLR, ST_NOTE_MAP, ST_HOLD_RD, ST_HOLD_CHK, ST_HOLD_WR
  } state_e;

  state_e state_q, state_d;

  logic [SW-1:0]     clr_idx_q, clr_idx_d;
  logic [VW-1:0]     idx_q, idx_d;
  logic [OP_W-1:0]   op_q;
  logic              p1_v_q, p2_v_q, p3_v_q;
  logic [VOICES-1:0] voice_vld_q;
  logic              m_valid_q, m_found_q, m_last_q;
  out_data_t         m_data_q;

  // request payload
  in_data_t             in_data;
  logic [SLOT_IN_W-1:0] slot_raw_q, q_q, q_mul, slot_red;
  logic [PW-1:0]        mod_prod;
  logic [SW-1:0]        slot_q;
  logic [LVL_W-1:0]     atk_q, sus_q, hf_q, rf_q;

  // steal search
  logic [PHASE_W-1:0] best_ph_q;
  logic [LVL_W-1:0]   best_lvl_q;
  logic [VW-1:0]      best_idx_q;
  logic [SW-1:0]      best_key_q;
  logic               better1;

  // memories and their ports
  ventry_t vmem [VOICES];
  sentry_t smem [SLOTS];
  ventry_t vrd_q, vwr_data, e1;
  logic    vrd_vld_q;
  logic    vrd_en, vwr_en;
  logic [VW-1:0] vrd_addr, vwr_addr;
  sentry_t slot_rd_q, swr_data;
  logic    srd_en, swr_en;
  logic [SW-1:0] srd_addr, swr_addr;

  // envelope pipeline
  logic               adv, in_acc, p3_act;
  logic [VW-1:0]      p1_idx_q, p2_idx_q, p3_idx_q;
  logic               rel1, ge1;
  logic [LVL_W-1:0]   diff1, a1, b1;
  ventry_t            p2_e_q, p3_e_q, w3;
  logic               p2_ge_q, p3_ge_q;
  logic [LVL_W-1:0]   p2_a_q, p2_b_q;
  logic [2*LVL_W-1:0] p3_prod_q;
  logic [LVL_W:0]     m3, sum3;
  logic [LVL_W+1:0]   t3;
  logic [LVL_W-1:0]   nl3;
  logic [PHASE_W-1:0] np3;

  // result to the output register
  logic                   emit, em_found, em_last;
  logic [VOICE_OUT_W-1:0] em_voice;
  logic [LVL_W-1:0]       em_level;
  logic [PHASE_W-1:0]     em_phase;

  assign adv     = !m_valid_q || m_axis_tready;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_data = in_data_t'(s_axis_tdata);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tlast  = m_last_q;

  // slot modulo SLOTS by reciprocal multiply, exact for every 11-bit slot
  assign mod_prod = PW'(slot_raw_q) * PW'(ModM);
  assign q_mul    = SLOT_IN_W'(q_q * SLOTS);
  assign slot_red = slot_raw_q - q_mul;

  // first stage: effective entry, multiplier operands, search compare
  assign e1      = vrd_vld_q ? vrd_q : RstEntry;
  assign rel1    = (e1.phase != PH_ATK) && (e1.phase != PH_HOLD);
  assign ge1     = (e1.level >= e1.sustain);
  assign diff1   = ge1 ? (e1.level - e1.sustain) : (e1.sustain - e1.level);
  assign a1      = rel1 ? e1.level : diff1;
  assign b1      = rel1 ? e1.rel_f : e1.hold_f;
  assign better1 = (p1_idx_q == '0) || (e1.phase < best_ph_q) ||
                   ((e1.phase == best_ph_q) && (e1.level < best_lvl_q));

  // last stage: new level and phase
  assign m3   = p3_prod_q[2*LVL_W-1:LVL_W-1];
  assign sum3 = {1'b0, p3_e_q.level} + {1'b0, p3_e_q.attack};
  assign t3   = {2'b00, p3_e_q.sustain} + {1'b0, m3};

  always_comb begin
    case (p3_e_q.phase)
      PH_ATK: begin
        nl3 = sum3[LVL_W] ? LVL_MAX : sum3[LVL_W-1:0];
        np3 = (nl3 > ONE_Q) ? PH_HOLD : PH_ATK;
      end
      PH_HOLD: begin
        if (p3_ge_q) begin
          nl3 = (t3 > {2'b00, LVL_MAX}) ? LVL_MAX : t3[LVL_W-1:0];
        end else begin
          nl3 = (m3 >= {1'b0, p3_e_q.sustain}) ? '0 : (p3_e_q.sustain - m3[LVL_W-1:0]);
        end
        np3 = PH_HOLD;
      end
      default: begin
        nl3 = m3[LVL_W] ? LVL_MAX : m3[LVL_W-1:0];
        np3 = p3_e_q.phase;
      end
    endcase
    w3 = p3_e_q;
    if (op_q == OP_ROW) begin
      w3.phase = PH_REL;
    end else begin
      w3.phase = np3;
      w3.level = nl3;
    end
  end

  assign p3_act = p3_v_q && adv && (op_q != OP_NOTE);

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    idx_d     = idx_q;
    vrd_en    = 1'b0;
    vrd_addr  = idx_q;
    srd_en    = 1'b0;
    srd_addr  = slot_q;
    swr_en    = 1'b0;
    swr_addr  = slot_q;
    swr_data  = '0;
    // write back and report from the end of the envelope pipeline
    vwr_en    = p3_act;
    vwr_addr  = p3_idx_q;
    vwr_data  = w3;
    emit      = p3_act && ((op_q == OP_STEP) || (p3_idx_q == LastVoice));
    em_voice  = (op_q == OP_STEP) ? VOICE_OUT_W'(p3_idx_q) : '0;
    em_level  = (op_q == OP_STEP) ? nl3 : '0;
    em_phase  = (op_q == OP_STEP) ? np3 : PH_REL;
    em_found  = 1'b1;
    em_last   = (p3_idx_q == LastVoice);

    case (state_q)
      ST_CLEAR: begin
        swr_en    = 1'b1;
        swr_addr  = clr_idx_q;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == LastSlot) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MOD1;
        end
      end
      ST_MOD1: begin
        state_d = ST_MOD2;
      end
      ST_MOD2: begin
        idx_d   = '0;
        state_d = (op_q == OP_HOLD) ? ST_HOLD_RD : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (adv) begin
          vrd_en = 1'b1;
          idx_d  = idx_q + 1'b1;
          if (idx_q == LastVoice) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!p1_v_q && !p2_v_q && !p3_v_q) begin
          state_d = (op_q == OP_NOTE) ? ST_NOTE_RD : ST_IDLE;
        end
      end
      ST_NOTE_RD: begin
        srd_en   = 1'b1;
        srd_addr = best_key_q;
        state_d  = ST_NOTE_CLR;
      end
      ST_NOTE_CLR: begin
        // drop the stolen voice's old mapping if it still points here
        if (slot_rd_q.vld && (slot_rd_q.owner == best_idx_q)) begin
          swr_en   = 1'b1;
          swr_addr = best_key_q;
        end
        vwr_en   = 1'b1;
        vwr_addr = best_idx_q;
        vwr_data = '{phase: PH_ATK, level: '0, attack: atk_q, sustain: sus_q,
                     hold_f: hf_q, rel_f: rf_q, key: slot_q};
        state_d  = ST_NOTE_MAP;
      end
      ST_NOTE_MAP: begin
        if (adv) begin
          swr_en   = 1'b1;
          swr_data = '{vld: 1'b1, owner: best_idx_q};
          emit     = 1'b1;
          em_voice = VOICE_OUT_W'(best_idx_q);
          em_level = '0;
          em_phase = PH_ATK;
          em_last  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_HOLD_RD: begin
        srd_en  = 1'b1;
        state_d = ST_HOLD_CHK;
      end
      ST_HOLD_CHK: begin
        if (slot_rd_q.vld) begin
          vrd_en   = 1'b1;
          vrd_addr = slot_rd_q.owner;
          state_d  = ST_HOLD_WR;
        end else if (adv) begin
          emit     = 1'b1;
          em_voice = '0;
          em_level = '0;
          em_phase = PH_REL;
          em_found = 1'b0;
          em_last  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_HOLD_WR: begin
        if (adv) begin
          vwr_en         = 1'b1;
          vwr_addr       = slot_rd_q.owner;
          vwr_data       = e1;
          vwr_data.phase = PH_HOLD;
          emit           = 1'b1;
          em_voice       = VOICE_OUT_W'(slot_rd_q.owner);
          em_level       = e1.level;
          em_phase       = PH_HOLD;
          em_last        = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      idx_q       <= '0;
      op_q        <= OP_ROW;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p3_v_q      <= 1'b0;
      voice_vld_q <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      m_found_q   <= 1'b0;
      m_last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      idx_q     <= idx_d;
      if (in_acc) begin
        op_q <= s_axis_tuser;
      end
      if (adv) begin
        p1_v_q <= (state_q == ST_SWEEP);
        p2_v_q <= p1_v_q;
        p3_v_q <= p2_v_q;
      end
      if (vwr_en) begin
        voice_vld_q[vwr_addr] <= 1'b1;
      end
      if (emit) begin
        m_valid_q <= 1'b1;
        m_data_q  <= '{phase: em_phase, level: em_level, voice: em_voice};
        m_found_q <= em_found;
        m_last_q  <= em_last;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_raw_q <= in_data.slot;
      atk_q      <= in_data.attack_step;
      sus_q      <= in_data.sustain_level;
      hf_q       <= in_data.hold_factor;
      rf_q       <= in_data.release_factor;
    end
    if (state_q == ST_MOD1) begin
      q_q <= SLOT_IN_W'(mod_prod >> ModK);
    end
    if (state_q == ST_MOD2) begin
      slot_q <= SW'(slot_red);
    end
    if (adv) begin
      p1_idx_q  <= idx_q;
      p2_idx_q  <= p1_idx_q;
      p2_e_q    <= e1;
      p2_ge_q   <= ge1;
      p2_a_q    <= a1;
      p2_b_q    <= b1;
      p3_idx_q  <= p2_idx_q;
      p3_e_q    <= p2_e_q;
      p3_ge_q   <= p2_ge_q;
      p3_prod_q <= p2_a_q * p2_b_q;
    end
    // keep the cheapest voice: lowest phase, then lowest level, then first index
    if (p1_v_q && adv && (op_q == OP_NOTE) && better1) begin
      best_ph_q  <= e1.phase;
      best_lvl_q <= e1.level;
      best_idx_q <= p1_idx_q;
      best_key_q <= e1.key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwr_en) begin
      vmem[vwr_addr] <= vwr_data;
    end
    if (vrd_en) begin
      vrd_q     <= vmem[vrd_addr];
      vrd_vld_q <= voice_vld_q[vrd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (swr_en) begin
      smem[swr_addr] <= swr_data;
    end
    if (srd_en) begin
      slot_rd_q <= smem[srd_addr];
    end
  end

  a_wr_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_v_q |-> !((state_q == ST_HOLD_WR) || (state_q == ST_NOTE_CLR)))
    else $error("voice memory write port claimed twice");

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!m_valid_q || m_axis_tready))
    else $error("result loaded over a waiting result");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!p1_v_q && !p2_v_q && !p3_v_q))
    else $error("request taken with the envelope pipeline busy");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for synth_voice_allocator_envelope: voice stealing, slot map and envelopes.
// Depends on svae_pkg and the block; drives requests on the input stream, checks each result.
module tb_top;
  import svae_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_PER_RUN = 52;
  localparam int MAX_PRINTED    = 40;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [SLOT_IN_W-1:0] slot;
    logic [LVL_W-1:0]     attack;
    logic [LVL_W-1:0]     sustain;
    logic [LVL_W-1:0]     hold_f;
    logic [LVL_W-1:0]     release_f;
  } voice_req_t;

  typedef struct {
    logic [VOICE_OUT_W-1:0] voice;
    logic [LVL_W-1:0]       level;
    logic [PHASE_W-1:0]     phase;
    logic                   found;
    logic                   last;
  } voice_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = OP_ROW;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  // Envelope and slot map state as the block should hold it
  logic [PHASE_W-1:0]   voice_ph    [NUM_VOICES];
  logic [LVL_W-1:0]     voice_lvl   [NUM_VOICES];
  logic [LVL_W-1:0]     voice_atk   [NUM_VOICES];
  logic [LVL_W-1:0]     voice_sus   [NUM_VOICES];
  logic [LVL_W-1:0]     voice_holdf [NUM_VOICES];
  logic [LVL_W-1:0]     voice_relf  [NUM_VOICES];
  logic [SLOT_IN_W-1:0] voice_key   [NUM_VOICES];
  int unsigned          owner_of_slot [NUM_SLOTS];
  bit                   slot_in_use   [NUM_SLOTS];

  voice_req_t    requests_to_send[$];
  voice_result_t voice_results_due[$];
  int unsigned   recent_slots[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int holds_found = 0;
  int ops_accepted[4] = '{0, 0, 0, 0};
  int stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  synth_voice_allocator_envelope dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic [LVL_W-1:0] clamp_level(logic [63:0] x);
    return (x > 64'(LVL_MAX)) ? LVL_MAX : x[LVL_W-1:0];
  endfunction

  function automatic void clear_voice_pool();
    for (int i = 0; i < NUM_VOICES; i++) begin
      voice_ph[i]    = PH_ATK;
      voice_lvl[i]   = '0;
      voice_atk[i]   = ATK_RST;
      voice_sus[i]   = SUS_RST;
      voice_holdf[i] = HOLD_RST;
      voice_relf[i]  = REL_RST;
      voice_key[i]   = '0;
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_in_use[s]   = 1'b0;
      owner_of_slot[s] = 0;
    end
  endfunction

  // Apply one accepted request to the voice pool and queue the results it causes
  function automatic void compute_voice_results(voice_req_t req);
    voice_result_t        res;
    int                   best;
    int unsigned          v;
    logic [SLOT_IN_W-1:0] old_key;
    logic [63:0]          lvl;
    logic [63:0]          sus;
    logic [63:0]          fac;
    logic [63:0]          mag;
    res.voice = '0;
    res.level = '0;
    res.phase = PH_REL;
    res.found = 1'b1;
    res.last  = 1'b1;
    ops_accepted[req.op]++;
    case (req.op)
      OP_ROW: begin
        for (int i = 0; i < NUM_VOICES; i++) voice_ph[i] = PH_REL;
        voice_results_due.push_back(res);
      end
      OP_NOTE: begin
        // steal: released before hold before attack, then quietest, then lowest index
        best = 0;
        for (int i = 1; i < NUM_VOICES; i++) begin
          if (voice_ph[i] < voice_ph[best] ||
              (voice_ph[i] == voice_ph[best] && voice_lvl[i] < voice_lvl[best]))
            best = i;
        end
        old_key = voice_key[best];
        if (slot_in_use[old_key] && owner_of_slot[old_key] == best) slot_in_use[old_key] = 1'b0;
        slot_in_use[req.slot]   = 1'b1;
        owner_of_slot[req.slot] = best;
        voice_ph[best]    = PH_ATK;
        voice_lvl[best]   = '0;
        voice_atk[best]   = req.attack;
        voice_sus[best]   = req.sustain;
        voice_holdf[best] = req.hold_f;
        voice_relf[best]  = req.release_f;
        voice_key[best]   = req.slot;
        res.voice = VOICE_OUT_W'(best);
        res.phase = PH_ATK;
        voice_results_due.push_back(res);
      end
      OP_HOLD: begin
        if (slot_in_use[req.slot]) begin
          v = owner_of_slot[req.slot];
          voice_ph[v] = PH_HOLD;
          res.voice = VOICE_OUT_W'(v);
          res.level = voice_lvl[v];
          res.phase = PH_HOLD;
          holds_found++;
        end else begin
          res.found = 1'b0;
        end
        voice_results_due.push_back(res);
      end
      default: begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          lvl = voice_lvl[i];
          if (voice_ph[i] == PH_ATK) begin
            lvl = clamp_level(lvl + voice_atk[i]);
            if (lvl > ONE_Q) voice_ph[i] = PH_HOLD;
          end else if (voice_ph[i] == PH_HOLD) begin
            sus = voice_sus[i];
            fac = voice_holdf[i];
            if (lvl >= sus) begin
              lvl = sus + (((lvl - sus) * fac) >> 24);
            end else begin
              mag = ((sus - lvl) * fac) >> 24;
              lvl = (mag >= sus) ? 64'd0 : sus - mag;
            end
            lvl = clamp_level(lvl);
          end else begin
            lvl = clamp_level((lvl * voice_relf[i]) >> 24);
          end
          voice_lvl[i] = lvl[LVL_W-1:0];
          res.voice = VOICE_OUT_W'(i);
          res.level = voice_lvl[i];
          res.phase = voice_ph[i];
          res.last  = (i == NUM_VOICES - 1);
          voice_results_due.push_back(res);
        end
      end
    endcase
  endfunction

  function automatic void queue_request(logic [OP_W-1:0] op, int unsigned slot,
                                        logic [LVL_W-1:0] atk, logic [LVL_W-1:0] sus,
                                        logic [LVL_W-1:0] hf, logic [LVL_W-1:0] rf);
    voice_req_t req;
    req.op        = op;
    req.slot      = SLOT_IN_W'(slot);
    req.attack    = atk;
    req.sustain   = sus;
    req.hold_f    = hf;
    req.release_f = rf;
    requests_to_send.push_back(req);
  endfunction

  // Mostly plausible envelope values, now and then an extreme or any 25-bit pattern
  function automatic logic [LVL_W-1:0] rand_q24(int unsigned lo, int unsigned hi);
    case ($urandom_range(9))
      0:       return '0;
      1:       return LVL_MAX;
      2:       return LVL_W'($urandom);
      default: return LVL_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic void queue_random_request();
    int unsigned roll;
    int unsigned slot;
    roll = $urandom_range(99);
    if (recent_slots.size() != 0 && $urandom_range(99) < 80)
      slot = recent_slots[$urandom_range(recent_slots.size() - 1)];
    else
      slot = $urandom_range(NUM_SLOTS - 1);
    if (roll < 6) begin
      queue_request(OP_ROW, $urandom_range(NUM_SLOTS - 1), '0, '0, '0, '0);
    end else if (roll < 36) begin
      if ($urandom_range(99) < 60) slot = $urandom_range(NUM_SLOTS - 1);
      recent_slots.push_back(slot);
      if (recent_slots.size() > 24) void'(recent_slots.pop_front());
      queue_request(OP_NOTE, slot, rand_q24(1 << 20, 1 << 24), rand_q24(0, 1 << 24),
                    rand_q24((1 << 24) - (1 << 22), 1 << 24),
                    rand_q24((1 << 24) - (1 << 22), 1 << 24));
    end else if (roll < 58) begin
      queue_request(OP_HOLD, slot, LVL_W'($urandom), LVL_W'($urandom),
                    LVL_W'($urandom), LVL_W'($urandom));
    end else begin
      queue_request(OP_STEP, slot, LVL_W'($urandom), LVL_W'($urandom),
                    LVL_W'($urandom), LVL_W'($urandom));
    end
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    // keep the log short when everything goes wrong
    if (mismatch_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Request driver: predict on acceptance, then offer the next request or idle
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    voice_req_t in_flight;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) compute_voice_results(in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = requests_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= in_flight.op;
          s_axis_tdata  <= in_data_t'{pad: 1'b0, release_factor: in_flight.release_f,
                                      hold_factor: in_flight.hold_f,
                                      sustain_level: in_flight.sustain,
                                      attack_step: in_flight.attack, slot: in_flight.slot};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_ready
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    out_data_t     got;
    voice_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = out_data_t'(m_axis_tdata);
      results_checked++;
      if (voice_results_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing due: voice %0d level %0d phase %0d",
                                  got.voice, got.level, got.phase));
      end else begin
        want = voice_results_due.pop_front();
        if (got.voice !== want.voice || got.level !== want.level ||
            got.phase !== want.phase || m_axis_tuser !== want.found ||
            m_axis_tlast !== want.last)
          report_mismatch($sformatf(
            "voice %0d/%0d level %0d/%0d phase %0d/%0d found %b/%b last %b/%b (got/want)",
            got.voice, want.voice, got.level, want.level, got.phase, want.phase,
            m_axis_tuser, want.found, m_axis_tlast, want.last));
      end
    end
  end

  // Any accepted request or result counts as progress; the slot map clear after reset fits well
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", stall_cycles);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic run_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int n = 0; n < count; n++) queue_random_request();
    while (requests_to_send.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clear_voice_pool();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unmapped hold, saturating attack and hold, steals of held and released voices
    queue_request(OP_HOLD, 5, '0, '0, '0, '0);
    queue_request(OP_STEP, 0, '0, '0, '0, '0);
    queue_request(OP_NOTE, 0, LVL_MAX, '0, LVL_MAX, LVL_MAX);
    queue_request(OP_STEP, 0, '0, '0, '0, '0);
    queue_request(OP_STEP, 0, '0, '0, '0, '0);
    queue_request(OP_HOLD, 0, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX);
    queue_request(OP_NOTE, 2047, ONE_Q, ONE_Q, '0, '0);
    queue_request(OP_HOLD, 0, '0, '0, '0, '0);
    queue_request(OP_NOTE, 2047, 25'h0800000, 25'h1800000, 25'h0800000, 25'h0F00000);
    queue_request(OP_STEP, 2047, '0, '0, '0, '0);
    queue_request(OP_NOTE, 1024, '0, LVL_MAX, ONE_Q, '0);
    queue_request(OP_STEP, 1024, '0, '0, '0, '0);
    queue_request(OP_NOTE, 1365, 25'h0AAAAAA, 25'h1555555, 25'h0AAAAAA, 25'h1555555);
    queue_request(OP_NOTE, 682, 25'h1555555, 25'h0AAAAAA, 25'h1555555, 25'h0AAAAAA);
    queue_request(OP_STEP, 0, '0, '0, '0, '0);
    queue_request(OP_ROW, 2047, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX);
    queue_request(OP_STEP, 0, '0, '0, '0, '0);
    queue_request(OP_HOLD, 1024, '0, '0, '0, '0);
    queue_request(OP_HOLD, 682, '0, '0, '0, '0);
    queue_request(OP_STEP, 0, '0, '0, '0, '0);
    queue_request(OP_NOTE, 100, 25'h0400000, 25'h0100000, 25'h1000000, 25'h0FFF000);
    queue_request(OP_STEP, 0, '0, '0, '0, '0);
    queue_request(OP_ROW, 0, '0, '0, '0, '0);
    queue_request(OP_STEP, 0, '0, '0, '0, '0);

    run_random(RANDOM_PER_RUN, 7, 78);
    run_random(RANDOM_PER_RUN, 78, 7);
    run_random(RANDOM_PER_RUN, 0, 0);

    // let the last request reach the valid line before waiting on it
    @(posedge clk_i);
    while (s_axis_tvalid || voice_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (voice_results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", voice_results_due.size()));

    $display("covered %0d row_start, %0d note_on, %0d hold (%0d mapped), %0d sample_step",
             ops_accepted[OP_ROW], ops_accepted[OP_NOTE], ops_accepted[OP_HOLD],
             holds_found, ops_accepted[OP_STEP]);
    $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/svae_pkg.sv
design/synth_voice_allocator_envelope.sv
bench/tb_top.sv
